[rtl/core/tcs_pkg.sv]
// tcs_pkg: shared types and codes of the TCP connection sequencer.
// Used by tcs_resp and tcp_connection_sequencer_unit; depends on nothing.
package tcs_pkg;

  // TCP flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  // command codes
  localparam logic [1:0] CMD_RX   = 2'd0;
  localparam logic [1:0] CMD_OPEN = 2'd1;
  localparam logic [1:0] CMD_SEND = 2'd2;

  // connection states
  localparam logic [1:0] ST_LISTEN      = 2'd0;
  localparam logic [1:0] ST_SYN_SENT    = 2'd1;
  localparam logic [1:0] ST_ESTABLISHED = 2'd2;

  // one input beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx_flags;
    logic [31:0] rx_seq;
    logic [10:0] rx_payload_len;
    logic        rx_is_mqtt;
    logic [7:0]  tx_flags;
    logic [7:0]  tx_data_len;
  } item_t;

  // decision for one item: first response, count and next state
  typedef struct packed {
    logic [1:0]  n_resp;      // 0, 1 or 2 responses
    logic [7:0]  flags;       // flags of the first response
    logic [31:0] seq;         // seq of the first response (second is seq + 1)
    logic [31:0] ack;         // ack of every response of this item
    logic        deliver;
    logic [1:0]  conn_nxt;
    logic [31:0] send_seq_nxt;
    logic [31:0] ack_value_nxt;
  } resp_t;

endpackage

[rtl/core/tcs_resp.sv]
// tcs_resp: response decision for one item from the current connection state.
// Pure combinational logic; uses tcs_pkg types and codes.
module tcs_resp (
  input  tcs_pkg::item_t item,
  input  logic [1:0]     conn,
  input  logic [31:0]    send_seq,
  input  logic [31:0]    ack_value,
  output tcs_pkg::resp_t resp
);

  logic        syn, fin, psh, ackf;
  logic [31:0] rx_ack;
  logic [31:0] tx_step;

  assign syn  = (item.rx_flags & tcs_pkg::FLAG_SYN) != 8'd0;
  assign fin  = (item.rx_flags & tcs_pkg::FLAG_FIN) != 8'd0;
  assign psh  = (item.rx_flags & tcs_pkg::FLAG_PSH) != 8'd0;
  assign ackf = (item.rx_flags & tcs_pkg::FLAG_ACK) != 8'd0;

  // ack taken from a received segment: data length for PUSH, else one
  assign rx_ack = item.rx_seq + (psh ? 32'(item.rx_payload_len) : 32'd1);

  // sequence advance of a send command
  always_comb begin
    if ((item.tx_flags & tcs_pkg::FLAG_PSH) != 8'd0) begin
      tx_step = 32'(item.tx_data_len);
    end else if ((item.tx_flags & (tcs_pkg::FLAG_SYN | tcs_pkg::FLAG_FIN)) != 8'd0) begin
      tx_step = 32'd1;
    end else begin
      tx_step = 32'd0;
    end
  end

  always_comb begin
    resp               = '0;
    resp.seq           = send_seq;
    resp.ack           = ack_value;
    resp.conn_nxt      = conn;
    resp.send_seq_nxt  = send_seq;
    resp.ack_value_nxt = ack_value;
    unique case (item.cmd)
      tcs_pkg::CMD_RX: begin
        unique case (conn)
          tcs_pkg::ST_LISTEN: begin
            resp.seq           = 32'd0;
            resp.ack           = 32'd0;
            resp.send_seq_nxt  = 32'd0;
            resp.ack_value_nxt = 32'd0;
            if (syn) begin
              resp.n_resp        = 2'd1;
              resp.ack           = rx_ack;
              resp.ack_value_nxt = rx_ack;
              resp.conn_nxt      = tcs_pkg::ST_ESTABLISHED;
              if (ackf) begin
                resp.flags = tcs_pkg::FLAG_ACK;
              end else begin
                resp.flags        = tcs_pkg::FLAG_SYN | tcs_pkg::FLAG_ACK;
                resp.send_seq_nxt = 32'd1;
              end
            end
          end
          tcs_pkg::ST_SYN_SENT: begin
            if (syn && ackf) begin
              resp.n_resp        = 2'd1;
              resp.flags         = tcs_pkg::FLAG_ACK;
              resp.ack           = rx_ack;
              resp.ack_value_nxt = rx_ack;
              resp.conn_nxt      = tcs_pkg::ST_ESTABLISHED;
            end
          end
          tcs_pkg::ST_ESTABLISHED: begin
            // FIN answers FIN|ACK first, PUSH then answers a plain ACK
            if (fin || psh) begin
              resp.ack           = rx_ack;
              resp.ack_value_nxt = rx_ack;
            end
            if (fin) begin
              resp.flags        = tcs_pkg::FLAG_FIN | tcs_pkg::FLAG_ACK;
              resp.send_seq_nxt = send_seq + 32'd1;
              resp.conn_nxt     = tcs_pkg::ST_LISTEN;
              resp.n_resp       = psh ? 2'd2 : 2'd1;
            end else if (psh) begin
              resp.flags  = tcs_pkg::FLAG_ACK;
              resp.n_resp = 2'd1;
            end
            resp.deliver = psh && item.rx_is_mqtt && (item.rx_payload_len != 11'd0);
          end
          default: begin
            resp.conn_nxt = tcs_pkg::ST_LISTEN;
          end
        endcase
      end
      tcs_pkg::CMD_OPEN: begin
        resp.n_resp        = 2'd1;
        resp.flags         = tcs_pkg::FLAG_SYN;
        resp.seq           = 32'd0;
        resp.ack           = 32'd0;
        resp.send_seq_nxt  = 32'd1;
        resp.ack_value_nxt = 32'd0;
        resp.conn_nxt      = tcs_pkg::ST_SYN_SENT;
      end
      tcs_pkg::CMD_SEND: begin
        resp.n_resp       = 2'd1;
        resp.flags        = item.tx_flags;
        resp.send_seq_nxt = send_seq + tx_step;
      end
      default: begin
        resp.n_resp = 2'd0;
      end
    endcase
  end

endmodule

[rtl/core/tcp_connection_sequencer_unit.sv]
// tcp_connection_sequencer_unit: top level of a simplified TCP endpoint.
// Depends on tcs_pkg and tcs_resp.
//
// Usage:
//   Input channel (in_*): one beat is a received segment, an open command or
//   a send command. A beat is taken at a rising edge with in_valid high and
//   in_stall low. Output channel (out_*): one beat per response segment with
//   flags, seq, ack, payload delivery, connection state and a last marker;
//   taken when out_valid is high and out_stall low.
//   A beat taken is held in the input register; its first response is loaded
//   into the output register when the item leaves the input register.
//   Throughput: one item per cycle for items with zero or one response while
//   the output is not stalled; a FIN with PUSH gives two responses and holds
//   the input for both, as the single output register sends one beat a cycle.
//   An input register and the output register part the two sides, so a new
//   item is taken while a response waits. When out_stall is high the output
//   beat holds and, once the input register is full, in_stall rises.
//   Reset (rst_n low, synchronous): state LISTEN, sequence and ack zero,
//   both channels empty.
module tcp_connection_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_flags,
  input  logic [31:0] in_rx_seq,
  input  logic [10:0] in_rx_payload_len,
  input  logic        in_rx_is_mqtt,
  input  logic [7:0]  in_tx_flags,
  input  logic [7:0]  in_tx_data_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_flags,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic        out_deliver_payload,
  output logic [1:0]  out_conn_now,
  output logic        out_last
);

  // input register
  logic           in_valid_r;
  tcs_pkg::item_t item_r;
  logic           in_accept;

  // connection state
  logic [1:0]  conn_r;
  logic [31:0] send_seq_r;
  logic [31:0] ack_value_r;

  // output register and pending second response
  logic        out_valid_r;
  logic        pend_valid_r;
  logic [7:0]  out_flags_r;
  logic [31:0] out_seq_r;
  logic [31:0] out_ack_r;
  logic        out_deliver_r;
  logic [1:0]  out_conn_r;
  logic        out_last_r;

  tcs_pkg::resp_t resp;
  logic           out_free;
  logic           consume;

  tcs_resp u_resp (
    .item      (item_r),
    .conn      (conn_r),
    .send_seq  (send_seq_r),
    .ack_value (ack_value_r),
    .resp      (resp)
  );

  // handshake control
  assign out_free  = !out_valid_r || !out_stall;
  assign consume   = in_valid_r &&
                     ((resp.n_resp == 2'd0) || (out_free && !pend_valid_r));
  assign in_stall  = in_valid_r && !consume;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.cmd            <= in_cmd;
      item_r.rx_flags       <= in_rx_flags;
      item_r.rx_seq         <= in_rx_seq;
      item_r.rx_payload_len <= in_rx_payload_len;
      item_r.rx_is_mqtt     <= in_rx_is_mqtt;
      item_r.tx_flags       <= in_tx_flags;
      item_r.tx_data_len    <= in_tx_data_len;
    end
  end

  // connection state advances when an item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r      <= tcs_pkg::ST_LISTEN;
      send_seq_r  <= 32'd0;
      ack_value_r <= 32'd0;
    end else if (consume) begin
      conn_r      <= resp.conn_nxt;
      send_seq_r  <= resp.send_seq_nxt;
      ack_value_r <= resp.ack_value_nxt;
    end
  end

  // output control: the pending ACK goes first, then a new item's response
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (pend_valid_r && out_free) begin
      pend_valid_r <= 1'b0;
    end else if (consume && (resp.n_resp != 2'd0)) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= (resp.n_resp == 2'd2);
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pend_valid_r && out_free) begin
      // second response of FIN with PUSH: ACK one past the FIN
      out_flags_r <= tcs_pkg::FLAG_ACK;
      out_seq_r   <= out_seq_r + 32'd1;
      out_last_r  <= 1'b1;
    end else if (consume && (resp.n_resp != 2'd0)) begin
      out_flags_r   <= resp.flags;
      out_seq_r     <= resp.seq;
      out_ack_r     <= resp.ack;
      out_deliver_r <= resp.deliver;
      out_conn_r    <= resp.conn_nxt;
      out_last_r    <= (resp.n_resp == 2'd1);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_flags           = out_flags_r;
  assign out_seq             = out_seq_r;
  assign out_ack             = out_ack_r;
  assign out_deliver_payload = out_deliver_r;
  assign out_conn_now        = out_conn_r;
  assign out_last            = out_last_r;

  // checks
  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending response without an output beat");

  a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !out_last_r)
    else $error("first of two responses marked last");

  a_resp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && (resp.n_resp != 2'd0)) |=> out_valid_r)
    else $error("response of a consumed item was lost");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !consume) |=> (in_valid_r && $stable(item_r)))
    else $error("stalled item left the input register");

endmodule

[verif/tb.sv]
// tb: self-checking testbench of tcp_connection_sequencer_unit.
// Drives segments and commands through the valid/stall input channel and compares every
// response beat with a built-in connection-state predictor; depends on tcs_pkg.
`timescale 1ns / 100ps

module tb;
  import tcs_pkg::*;

  // unused command code: the block ignores it
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_GAP      = 16;

  // one expected or observed response beat
  typedef struct packed {
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic        deliver;
    logic [1:0]  conn;
    logic        last;
  } seg_t;

  // one directed stimulus row; pinned rows carry a hand-typed first response
  typedef struct packed {
    item_t it;
    logic  pinned;
    seg_t  first;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_rx_flags;
  logic [31:0] in_rx_seq;
  logic [10:0] in_rx_payload_len;
  logic        in_rx_is_mqtt;
  logic [7:0]  in_tx_flags;
  logic [7:0]  in_tx_data_len;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_flags;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic        out_deliver_payload;
  logic [1:0]  out_conn_now;
  logic        out_last;

  tcp_connection_sequencer_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_rx_flags         (in_rx_flags),
    .in_rx_seq           (in_rx_seq),
    .in_rx_payload_len   (in_rx_payload_len),
    .in_rx_is_mqtt       (in_rx_is_mqtt),
    .in_tx_flags         (in_tx_flags),
    .in_tx_data_len      (in_tx_data_len),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flags           (out_flags),
    .out_seq             (out_seq),
    .out_ack             (out_ack),
    .out_deliver_payload (out_deliver_payload),
    .out_conn_now        (out_conn_now),
    .out_last            (out_last)
  );

  // predicted connection state
  logic [1:0]  conn_st;
  logic [31:0] snd_seq;
  logic [31:0] ack_val;

  // responses of the item being predicted, then the queue of pending responses
  seg_t        step_seg[2];
  int          step_n;
  seg_t        resp_q[$];
  row_t        dir_rows[$];

  int          errors;
  int          cycles;
  int          items_sent;
  int          segs_seen;
  int          dual_items;
  int          snd_pct;
  int          stall_pct;
  bit          hold_go;
  logic        rx_hold;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d responses pending", $time, cycles,
               resp_q.size());
      $display("[tcp_connection_sequencer_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stall, forced high during the hold-off
  always @(posedge clk) begin
    out_stall <= rx_hold || (stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin : hold_off
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // ack taken from a received segment: PUSH first, else SYN or FIN
  function automatic void take_rx_ack(input item_t it);
    if ((it.rx_flags & FLAG_PSH) != 8'h00)
      ack_val = it.rx_seq + 32'(it.rx_payload_len);
    else if ((it.rx_flags & (FLAG_SYN | FLAG_FIN)) != 8'h00)
      ack_val = it.rx_seq + 32'd1;
  endfunction

  // one outgoing segment; SYN/FIN take one number, PUSH the data length
  function automatic void emit_seg(input logic [7:0] flags, input logic [7:0] dlen);
    step_seg[step_n] = '{flags: flags, seq: snd_seq, ack: ack_val,
                         deliver: 1'b0, conn: ST_LISTEN, last: 1'b0};
    step_n++;
    if ((flags & FLAG_PSH) != 8'h00)
      snd_seq = snd_seq + 32'(dlen);
    else if ((flags & (FLAG_SYN | FLAG_FIN)) != 8'h00)
      snd_seq = snd_seq + 32'd1;
  endfunction

  // responses of one accepted item, left in step_seg / step_n
  function automatic void predict_item(input item_t it);
    logic syn, ackf, fin, psh, dlv;
    syn  = (it.rx_flags & FLAG_SYN) != 8'h00;
    ackf = (it.rx_flags & FLAG_ACK) != 8'h00;
    fin  = (it.rx_flags & FLAG_FIN) != 8'h00;
    psh  = (it.rx_flags & FLAG_PSH) != 8'h00;
    dlv  = 1'b0;
    step_n = 0;
    case (it.cmd)
      CMD_RX: begin
        if (conn_st == ST_LISTEN) begin
          snd_seq = '0;
          ack_val = '0;
          if (syn) begin
            take_rx_ack(it);
            emit_seg(ackf ? FLAG_ACK : (FLAG_SYN | FLAG_ACK), 8'd0);
            conn_st = ST_ESTABLISHED;
          end
        end else if (conn_st == ST_SYN_SENT) begin
          if (syn && ackf) begin
            take_rx_ack(it);
            emit_seg(FLAG_ACK, 8'd0);
            conn_st = ST_ESTABLISHED;
          end
        end else if (conn_st == ST_ESTABLISHED) begin
          if (fin) begin
            conn_st = ST_LISTEN;
            take_rx_ack(it);
            emit_seg(FLAG_FIN | FLAG_ACK, 8'd0);
          end
          if (psh) begin
            dlv = it.rx_is_mqtt && (it.rx_payload_len != 11'd0);
            take_rx_ack(it);
            emit_seg(FLAG_ACK, 8'd0);
          end
        end else begin
          conn_st = ST_LISTEN;
        end
      end
      CMD_OPEN: begin
        snd_seq = '0;
        ack_val = '0;
        conn_st = ST_SYN_SENT;
        emit_seg(FLAG_SYN, 8'd0);
      end
      CMD_SEND: emit_seg(it.tx_flags, it.tx_data_len);
      default: ;
    endcase
    // state and delivery are those after the whole step
    for (int k = 0; k < step_n; k++) begin
      step_seg[k].deliver = dlv;
      step_seg[k].conn    = conn_st;
      step_seg[k].last    = (k == step_n - 1);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic item_t mk_item(input logic [1:0] cmd, input logic [7:0] rflags,
                                    input logic [31:0] rseq, input logic [10:0] rlen,
                                    input logic mqtt, input logic [7:0] tflags,
                                    input logic [7:0] tlen);
    item_t it;
    it.cmd            = cmd;
    it.rx_flags       = rflags;
    it.rx_seq         = rseq;
    it.rx_payload_len = rlen;
    it.rx_is_mqtt     = mqtt;
    it.tx_flags       = tflags;
    it.tx_data_len    = tlen;
    return it;
  endfunction

  function automatic void add_row(input item_t it, input logic pinned, input seg_t first);
    row_t r;
    r.it     = it;
    r.pinned = pinned;
    r.first  = first;
    dir_rows.push_back(r);
  endfunction

  // random item, mostly a well-formed next step for the current connection state
  function automatic item_t rand_item();
    item_t it;
    int    r;
    int    f;
    it = mk_item(CMD_RX, 8'($urandom), $urandom, 11'($urandom_range(2047)),
                 1'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(3) == 0) it.rx_payload_len = 11'($urandom_range(3));
    r = $urandom_range(99);
    f = $urandom_range(99);
    if (r < 8) begin
      it.cmd = CMD_OPEN;
    end else if (r < 30) begin
      it.cmd = CMD_SEND;
      if (f < 40)      it.tx_flags = FLAG_PSH | FLAG_ACK;
      else if (f < 50) it.tx_flags = FLAG_SYN;
      else if (f < 60) it.tx_flags = FLAG_FIN | FLAG_ACK;
      else if (f < 70) it.tx_flags = FLAG_ACK;
    end else if (r < 33) begin
      it.cmd = CMD_NONE;
    end else if (r >= 42) begin
      // well-formed segment; r in 33..41 keeps the random flag byte as noise
      case (conn_st)
        ST_LISTEN:   it.rx_flags = (f < 60) ? FLAG_SYN : (f < 90) ? (FLAG_SYN | FLAG_ACK)
                                                             : FLAG_ACK;
        ST_SYN_SENT: it.rx_flags = (f < 80) ? (FLAG_SYN | FLAG_ACK) : FLAG_SYN;
        default: begin
          if (f < 60)      it.rx_flags = FLAG_PSH | FLAG_ACK;
          else if (f < 75) it.rx_flags = FLAG_FIN | FLAG_ACK;
          else if (f < 90) it.rx_flags = FLAG_FIN | FLAG_PSH | FLAG_ACK;
          else             it.rx_flags = FLAG_ACK;
        end
      endcase
    end
    return it;
  endfunction

  // offer one item after a random gap, hold it until taken, then queue its responses
  task automatic push_item(input item_t it, input logic pinned, input seg_t first);
    int gap;
    gap = 0;
    while (snd_pct > 0 && gap < MAX_GAP && $urandom_range(99) < snd_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= it.cmd;
    in_rx_flags       <= it.rx_flags;
    in_rx_seq         <= it.rx_seq;
    in_rx_payload_len <= it.rx_payload_len;
    in_rx_is_mqtt     <= it.rx_is_mqtt;
    in_tx_flags       <= it.tx_flags;
    in_tx_data_len    <= it.tx_data_len;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    if (pinned && step_n > 0) step_seg[0] = first;
    for (int k = 0; k < step_n; k++) resp_q.push_back(step_seg[k]);
    items_sent++;
    if (step_n == 2) dual_items++;
  endtask

  // random items until `count` of them have caused responses
  task automatic run_random(input int count, input int s_pct, input int r_pct);
    int   done_n;
    seg_t none;
    none   = '0;
    done_n = 0;
    snd_pct   = s_pct;
    stall_pct = r_pct;
    while (done_n < count) begin
      push_item(rand_item(), 1'b0, none);
      if (step_n > 0) done_n++;
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic chk_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // response beats against the oldest pending expectation
  always @(posedge clk) begin
    seg_t want;
    if (rst_n && out_valid && !out_stall) begin
      segs_seen++;
      if (resp_q.size() == 0) begin
        $display("%0t unexpected response: flags %h seq %h ack %h", $time, out_flags,
                 out_seq, out_ack);
        errors++;
      end else begin
        want = resp_q.pop_front();
        chk_field("flags", 32'(want.flags), 32'(out_flags));
        chk_field("seq", want.seq, out_seq);
        chk_field("ack", want.ack, out_ack);
        chk_field("deliver", 32'(want.deliver), 32'(out_deliver_payload));
        chk_field("conn_now", 32'(want.conn), 32'(out_conn_now));
        chk_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    seg_t none;
    none       = '0;
    errors     = 0;
    cycles     = 0;
    items_sent = 0;
    segs_seen  = 0;
    dual_items = 0;
    snd_pct    = 0;
    stall_pct  = 0;
    hold_go    = 1'b0;
    conn_st    = ST_LISTEN;
    snd_seq    = '0;
    ack_val    = '0;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_cmd            <= CMD_RX;
    in_rx_flags       <= '0;
    in_rx_seq         <= '0;
    in_rx_payload_len <= '0;
    in_rx_is_mqtt     <= 1'b0;
    in_tx_flags       <= '0;
    in_tx_data_len    <= '0;

    // directed table
    // segment without SYN in listen: nothing sent
    add_row(mk_item(CMD_RX, 8'h00, 32'h0, 11'd0, 1'b0, 8'h00, 8'h00), 1'b0, none);
    // passive open, received sequence wraps to ack zero
    add_row(mk_item(CMD_RX, FLAG_SYN, 32'hFFFF_FFFF, 11'd2047, 1'b1, 8'h00, 8'h00), 1'b1,
            '{flags: FLAG_SYN | FLAG_ACK, seq: 32'd0, ack: 32'd0, deliver: 1'b0,
              conn: ST_ESTABLISHED, last: 1'b1});
    // largest payload, ack wraps, payload delivered
    add_row(mk_item(CMD_RX, FLAG_PSH | FLAG_ACK, 32'hFFFF_FF00, 11'd2047, 1'b1,
                    8'h00, 8'h00), 1'b1,
            '{flags: FLAG_ACK, seq: 32'd1, ack: 32'h0000_06FF, deliver: 1'b1,
              conn: ST_ESTABLISHED, last: 1'b1});
    // empty push with app payload flag: not delivered
    add_row(mk_item(CMD_RX, FLAG_PSH, 32'h1234_5678, 11'd0, 1'b1, 8'h00, 8'h00), 1'b0, none);
    // push without app payload flag
    add_row(mk_item(CMD_RX, FLAG_PSH | FLAG_ACK, 32'h0000_0100, 11'd5, 1'b0, 8'h00, 8'h00),
            1'b0, none);
    // ACK only while established: nothing sent
    add_row(mk_item(CMD_RX, FLAG_ACK, 32'h0, 11'd9, 1'b1, 8'h00, 8'h00), 1'b0, none);
    // FIN with PUSH: two responses, both in listen
    add_row(mk_item(CMD_RX, FLAG_FIN | FLAG_PSH | FLAG_ACK, 32'h0000_0200, 11'd7, 1'b1,
                    8'h00, 8'h00), 1'b0, none);
    // passive open answered with ACK when SYN comes with ACK
    add_row(mk_item(CMD_RX, FLAG_SYN | FLAG_ACK, 32'h8000_0000, 11'd0, 1'b0, 8'h00, 8'h00),
            1'b0, none);
    // plain FIN closes
    add_row(mk_item(CMD_RX, FLAG_FIN, 32'h0000_0042, 11'd3, 1'b0, 8'h00, 8'h00), 1'b0, none);
    // send in listen
    add_row(mk_item(CMD_SEND, 8'h00, 32'h0, 11'd0, 1'b0, FLAG_PSH, 8'd10), 1'b0, none);
    // active open
    add_row(mk_item(CMD_OPEN, 8'hFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, 8'hFF, 8'hFF), 1'b1,
            '{flags: FLAG_SYN, seq: 32'd0, ack: 32'd0, deliver: 1'b0,
              conn: ST_SYN_SENT, last: 1'b1});
    // SYN alone and PUSH are ignored in SYN sent
    add_row(mk_item(CMD_RX, FLAG_SYN, 32'h5, 11'd0, 1'b0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_item(CMD_RX, FLAG_PSH | FLAG_FIN, 32'h5, 11'd4, 1'b1, 8'h00, 8'h00), 1'b0,
            none);
    // SYN|ACK completes the open, sequence wraps
    add_row(mk_item(CMD_RX, FLAG_SYN | FLAG_ACK, 32'hFFFF_FFFF, 11'd0, 1'b0, 8'h00, 8'h00),
            1'b1, '{flags: FLAG_ACK, seq: 32'd1, ack: 32'd0, deliver: 1'b0,
                    conn: ST_ESTABLISHED, last: 1'b1});
    // sends with all flags, no flags, SYN and FIN
    add_row(mk_item(CMD_SEND, 8'h00, 32'h0, 11'd0, 1'b0, 8'hFF, 8'hFF), 1'b0, none);
    add_row(mk_item(CMD_SEND, 8'hFF, 32'h0, 11'd0, 1'b1, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_item(CMD_SEND, 8'h00, 32'h0, 11'd0, 1'b0, FLAG_SYN, 8'd200), 1'b0, none);
    add_row(mk_item(CMD_SEND, 8'h00, 32'h0, 11'd0, 1'b0, FLAG_FIN, 8'd1), 1'b0, none);
    // unused command: ignored
    add_row(mk_item(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, 8'hFF, 8'hFF), 1'b0,
            none);
    // every flag set while established: FIN|ACK then ACK
    add_row(mk_item(CMD_RX, 8'hFF, 32'hFFFF_FFFE, 11'd2047, 1'b1, 8'h00, 8'h00), 1'b0, none);
    // every flag set in listen: answered with ACK, ack from the PUSH rule
    add_row(mk_item(CMD_RX, 8'hFF, 32'h0000_1000, 11'd16, 1'b1, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_item(CMD_RX, FLAG_FIN | FLAG_PSH | FLAG_ACK, 32'h0000_1010, 11'd0, 1'b0,
                    8'h00, 8'h00), 1'b0, none);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_pct   = 29;
    stall_pct = 29;
    foreach (dir_rows[i]) push_item(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].first);

    // random phases: no idling, sender idle, receiver stalling, both
    run_random(80, 0, 0);
    run_random(115, 55, 0);
    run_random(115, 0, 55);
    run_random(115, 29, 29);
    // long receiver hold-off with the sender offering back to back
    hold_go = 1'b1;
    run_random(40, 0, 0);

    // drain
    snd_pct   = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (resp_q.size() != 0) begin
      $display("%0t %0d responses never arrived", $time, resp_q.size());
      errors++;
    end
    $display("covered %0d items (%0d with two responses), %0d response beats checked",
             items_sent, dual_items, segs_seen);
    $display("phases: directed, free flow, sender gaps, receiver stalls, both, hold-off");
    if (errors == 0)
      $display("[tcp_connection_sequencer_unit] OK");
    else
      $display("[tcp_connection_sequencer_unit] ERROR");
    $finish;
  end

endmodule
